[sv/y2r_pkg.sv]
package y2r_pkg;

  // field widths
  localparam int PIX_W  = 8;
  localparam int PROD_W = 20;   // signed coefficient products, |x| < 2^18
  localparam int MAG_W  = 18;   // magnitude of a product
  localparam int QUO_W  = 9;    // magnitude of an offset, at most 260
  localparam int OFF_W  = 10;   // signed offset
  localparam int SUM_W  = 11;   // signed luma + offset

  // chroma channels, one lane of the offset datapath each
  localparam int NUM_CH = 3;
  localparam int CH_R   = 0;
  localparam int CH_G   = 1;
  localparam int CH_B   = 2;

  typedef logic [PIX_W-1:0]         pix_t;
  typedef logic signed [PIX_W-1:0]  chroma_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [MAG_W-1:0]         mag_t;
  typedef logic [QUO_W-1:0]         quo_t;
  typedef logic signed [OFF_W-1:0]  off_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // coefficients scaled by 1000
  localparam prod_t COEF_RV = 20'sd1140;
  localparam prod_t COEF_GU = -20'sd395;
  localparam prod_t COEF_GV = -20'sd581;
  localparam prod_t COEF_BU = 20'sd2032;

  // divide by 1000: q = (m * RECIP_K) >> RECIP_S, exact for every m < 2^MAG_W
  localparam int RECIP_S = 27;
  localparam int RECIP_W = 18;
  localparam int WIDE_W  = MAG_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'((2 ** RECIP_S + 999) / 1000);

  localparam pix_t PIX_MAX = '1;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  typedef struct packed {
    off_t red;
    off_t green;
    off_t blue;
  } offsets_t;

  typedef struct packed {
    pix_t red;
    pix_t green;
    pix_t blue;
  } rgb_t;

  // magnitude of a signed product
  function automatic mag_t mag_of(prod_t p);
    prod_t n;
    n = -p;
    return p[PROD_W-1] ? n[MAG_W-1:0] : p[MAG_W-1:0];
  endfunction

  // signed offset from magnitude and sign
  function automatic off_t apply_sign(quo_t q, logic neg);
    off_t m;
    m = $signed({1'b0, q});
    return neg ? -m : m;
  endfunction

  // saturate to 0..255
  function automatic pix_t clamp_pix(sum_t s);
    pix_t p;
    if (s[SUM_W-1]) begin
      p = '0;
    end else if (|s[SUM_W-2:PIX_W]) begin
      p = PIX_MAX;
    end else begin
      p = s[PIX_W-1:0];
    end
    return p;
  endfunction

endpackage

[sv/y2r_if.sv]
interface y2r_in_if;
  logic           valid;
  logic           ready;
  y2r_pkg::pix_t  luma_first;
  y2r_pkg::pix_t  chroma_v;
  y2r_pkg::pix_t  luma_second;
  y2r_pkg::pix_t  chroma_u;

  modport source (output valid, output luma_first, output chroma_v,
                  output luma_second, output chroma_u, input ready);
  modport sink   (input valid, input luma_first, input chroma_v,
                  input luma_second, input chroma_u, output ready);
endinterface

interface y2r_out_if;
  logic           valid;
  logic           ready;
  y2r_pkg::pix_t  red_first;
  y2r_pkg::pix_t  green_first;
  y2r_pkg::pix_t  blue_first;
  y2r_pkg::pix_t  red_second;
  y2r_pkg::pix_t  green_second;
  y2r_pkg::pix_t  blue_second;

  modport source (output valid, output red_first, output green_first,
                  output blue_first, output red_second, output green_second,
                  output blue_second, input ready);
  modport sink   (input valid, input red_first, input green_first,
                  input blue_first, input red_second, input green_second,
                  input blue_second, output ready);
endinterface

[sv/y2r_chroma.sv]
module y2r_chroma (
  input  logic                clk,
  input  y2r_pkg::stage_en_t  en,
  input  y2r_pkg::pix_t       chroma_v,
  input  y2r_pkg::pix_t       chroma_u,
  output y2r_pkg::offsets_t   offs
);
  import y2r_pkg::*;

  chroma_t dv;
  chroma_t du;
  prod_t   prod [NUM_CH];

  mag_t    mag_r [NUM_CH];
  logic    neg_r [NUM_CH];

  logic [WIDE_W-1:0] recip [NUM_CH];
  quo_t    quo_r  [NUM_CH];
  logic    sgn_r  [NUM_CH];

  // remove the chroma bias: flipping the top bit gives x - 128 as signed
  assign dv = {~chroma_v[PIX_W-1], chroma_v[PIX_W-2:0]};
  assign du = {~chroma_u[PIX_W-1], chroma_u[PIX_W-2:0]};

  // scaled offsets, one product lane per channel
  assign prod[CH_R] = PROD_W'(dv) * COEF_RV;
  assign prod[CH_G] = PROD_W'(du) * COEF_GU + PROD_W'(dv) * COEF_GV;
  assign prod[CH_B] = PROD_W'(du) * COEF_BU;

  // stage 1: hold magnitude and sign
  always_ff @(posedge clk) begin
    if (en.s1) begin
      for (int i = 0; i < NUM_CH; i++) begin
        mag_r[i] <= mag_of(prod[i]);
        neg_r[i] <= prod[i][PROD_W-1];
      end
    end
  end

  // divide magnitudes by 1000 through the reciprocal
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      recip[i] = WIDE_W'(mag_r[i]) * WIDE_W'(RECIP_K);
    end
  end

  // stage 2: hold quotient magnitude and sign
  always_ff @(posedge clk) begin
    if (en.s2) begin
      for (int i = 0; i < NUM_CH; i++) begin
        quo_r[i] <= recip[i][RECIP_S +: QUO_W];
        sgn_r[i] <= neg_r[i];
      end
    end
  end

  // restore sign: truncation toward zero
  assign offs.red   = apply_sign(quo_r[CH_R], sgn_r[CH_R]);
  assign offs.green = apply_sign(quo_r[CH_G], sgn_r[CH_G]);
  assign offs.blue  = apply_sign(quo_r[CH_B], sgn_r[CH_B]);

endmodule

[sv/y2r_lane.sv]
module y2r_lane (
  input  y2r_pkg::pix_t      luma,
  input  y2r_pkg::offsets_t  offs,
  output y2r_pkg::rgb_t      px
);
  import y2r_pkg::*;

  sum_t luma_s;
  sum_t sum_r;
  sum_t sum_g;
  sum_t sum_b;

  // add each offset to the luma of this pixel
  assign luma_s = $signed({{(SUM_W-PIX_W){1'b0}}, luma});
  assign sum_r  = luma_s + SUM_W'($signed(offs.red));
  assign sum_g  = luma_s + SUM_W'($signed(offs.green));
  assign sum_b  = luma_s + SUM_W'($signed(offs.blue));

  // saturate
  assign px.red   = clamp_pix(sum_r);
  assign px.green = clamp_pix(sum_g);
  assign px.blue  = clamp_pix(sum_b);

endmodule

[sv/yuy2_to_rgb888_converter.sv]
// Channel   Dir  Word
// in_ch     in   luma_first, chroma_v, luma_second, chroma_u (8 bits each)
// out_ch    out  red/green/blue of first and second pixel (8 bits each)
//
// One word per cycle sustained while out_ch.ready stays high; an accepted word
// passes the stage 1, stage 2 and output registers before out_ch.valid rises.
// Stage 1 forms the scaled chroma products, stage 2 divides by 1000 through a
// reciprocal multiplier, stage 3 is the output register fed by two pixel lanes.
// Each stage advances when empty or when the next one moves, so bubbles fill under a stall.
// Reset clears the stage valid bits; in_ch.ready stays low during reset.
module yuy2_to_rgb888_converter (
  input  logic        clk,
  input  logic        rst_n,
  y2r_in_if.sink      in_ch,
  y2r_out_if.source   out_ch
);
  import y2r_pkg::*;

  stage_en_t en;
  logic      accept;
  logic      v1_r, v1_nxt;
  logic      v2_r, v2_nxt;
  logic      v3_r, v3_nxt;

  pix_t      y0_s1_r, y1_s1_r;
  pix_t      y0_s2_r, y1_s2_r;
  offsets_t  offs;
  rgb_t      px_first;
  rgb_t      px_second;
  rgb_t      first_r;
  rgb_t      second_r;

  // stage enables: advance when empty or when the next stage moves
  assign en.s3 = !v3_r || out_ch.ready;
  assign en.s2 = !v2_r || en.s3;
  assign en.s1 = !v1_r || en.s2;

  assign in_ch.ready = rst_n && en.s1;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    v1_nxt = en.s1 ? accept : v1_r;
    v2_nxt = en.s2 ? v1_r   : v2_r;
    v3_nxt = en.s3 ? v2_r   : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // carry luma alongside the chroma pipeline
  always_ff @(posedge clk) begin
    if (en.s1) begin
      y0_s1_r <= in_ch.luma_first;
      y1_s1_r <= in_ch.luma_second;
    end
    if (en.s2) begin
      y0_s2_r <= y0_s1_r;
      y1_s2_r <= y1_s1_r;
    end
  end

  y2r_chroma u_chroma (
    .clk      (clk),
    .en       (en),
    .chroma_v (in_ch.chroma_v),
    .chroma_u (in_ch.chroma_u),
    .offs     (offs)
  );

  y2r_lane u_lane_first (
    .luma (y0_s2_r),
    .offs (offs),
    .px   (px_first)
  );

  y2r_lane u_lane_second (
    .luma (y1_s2_r),
    .offs (offs),
    .px   (px_second)
  );

  // merge both lanes into the output word
  always_ff @(posedge clk) begin
    if (en.s3) begin
      first_r  <= px_first;
      second_r <= px_second;
    end
  end

  assign out_ch.valid        = v3_r;
  assign out_ch.red_first    = first_r.red;
  assign out_ch.green_first  = first_r.green;
  assign out_ch.blue_first   = first_r.blue;
  assign out_ch.red_second   = second_r.red;
  assign out_ch.green_second = second_r.green;
  assign out_ch.blue_second  = second_r.blue;

endmodule

[sv/y2r_checker.sv]
module y2r_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [47:0] out_data
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed under stall");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a free output side never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled while output side is free");

  // a fresh output word follows an accept through the stage 1, stage 2 and output registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 3))
    else $error("output word without matching input word");

endmodule

bind yuy2_to_rgb888_converter y2r_checker u_y2r_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  ({out_ch.red_first, out_ch.green_first, out_ch.blue_first,
               out_ch.red_second, out_ch.green_second, out_ch.blue_second})
);
